// ----- src/glyph_contour_tracer_unit_assert.svh -----
// Assertion macros used by the tracer RTL.
`ifndef GLYPH_CONTOUR_TRACER_UNIT_ASSERT_SVH
`define GLYPH_CONTOUR_TRACER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GCT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define GCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GCT_ASSERT(label, expr, msg)
`define GCT_ASSERT_IMP(label, ante, cons, msg)
`define GCT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/gct_pkg.sv -----
package gct_pkg;

  localparam int COORD_BITS = 16;
  localparam int GLYPH_W    = 4;
  localparam int GLYPH_H    = 5;
  localparam int MAX_OUT    = 60;
  localparam int WALK_LIMIT = 120;
  localparam int CHAR_FIRST = 32;
  localparam int CHAR_END   = 127;
  localparam int BOX_INDEX  = 95;
  localparam int RECIP_H    = 3277;
  localparam int RECIP_SH   = 14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP_Q,
    ST_PREP_R,
    ST_SCAN,
    ST_WALK,
    ST_CLOSE,
    ST_FLUSH
  } st_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  localparam logic KIND_JUMP  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [9:0]            wq;
    logic [1:0]            wr;
    logic [9:0]            hq;
    logic [2:0]            hr;
  } scale_cfg_t;

  localparam logic [19:0] GLYPH_ROM [96] = '{
    20'h00000, 20'h44404, 20'hAA000, 20'h6F6F6, 20'h7A65E, 20'h7E47E, 20'h694A7, 20'h22000,
    20'h48884, 20'h42224, 20'h96F69, 20'h02720, 20'h00024, 20'h00700, 20'h00004, 20'h11248,
    20'h6BFD6, 20'h26222, 20'hE168F, 20'hE161E, 20'h26AF2, 20'hF8E1E, 20'h68E96, 20'hF1248,
    20'h69696, 20'h69F16, 20'h04040, 20'h04048, 20'h24842, 20'h0F0F0, 20'h42124, 20'h69202,
    20'h69356, 20'hF9F99, 20'hE9E9E, 20'hF888F, 20'hE999E, 20'hF8E8F, 20'hF8E88, 20'hF8B9F,
    20'h99F99, 20'hE444E, 20'hF1196, 20'h9ACA9, 20'h8888F, 20'hEFFDD, 20'h9DB99, 20'hF999F,
    20'hE9E88, 20'hF99BF, 20'hE9E99, 20'h7861E, 20'hF2222, 20'h9999F, 20'h999A4, 20'h9BBFE,
    20'h99699, 20'h99716, 20'hF248F, 20'hE888E, 20'h88421, 20'h71117, 20'h4A000, 20'h0000F,
    20'h42000, 20'h05BB5, 20'h88E9E, 20'h07887, 20'h11797, 20'h69F87, 20'h34E44, 20'h79717,
    20'h88E99, 20'h02022, 20'h10116, 20'h8ACA9, 20'hC444E, 20'h0EDDD, 20'h0E999, 20'h06996,
    20'h0E9E8, 20'h06971, 20'h0BC88, 20'h0742E, 20'h4E443, 20'h09996, 20'h09966, 20'h09FF6,
    20'h09669, 20'h09716, 20'h0F24F, 20'h64C46, 20'h44444, 20'hC464C, 20'h005A0, 20'hF999F
  };

  function automatic logic [19:0] glyph_lookup(logic [7:0] code);
    logic [6:0] idx;
    idx = 7'(BOX_INDEX);
    if (code >= 8'(CHAR_FIRST) && code < 8'(CHAR_END)) begin
      idx = 7'(code - 8'(CHAR_FIRST));
    end
    return GLYPH_ROM[idx];
  endfunction

  function automatic logic [2:0] div_h_small(logic [4:0] v);
    logic [2:0] q;
    priority if (v >= 5'(6 * GLYPH_H)) begin
      q = 3'd6;
    end else if (v >= 5'(5 * GLYPH_H)) begin
      q = 3'd5;
    end else if (v >= 5'(4 * GLYPH_H)) begin
      q = 3'd4;
    end else if (v >= 5'(3 * GLYPH_H)) begin
      q = 3'd3;
    end else if (v >= 5'(2 * GLYPH_H)) begin
      q = 3'd2;
    end else if (v >= 5'(GLYPH_H)) begin
      q = 3'd1;
    end else begin
      q = 3'd0;
    end
    return q;
  endfunction

endpackage

// ----- src/glyph_contour_tracer_unit.sv -----
// After start, busy stays high while R results come out in C contours (60 results at most).
// The final result strobes in the cycle in which busy falls; results come at most one a cycle.
// One character at a time: start is taken only while idle, and the busy span is set by
// the scan of the 30 corners and the one-step-a-cycle contour walk through the point scaler.
// Reset: synchronous, active low; the unit returns idle and drops any pending result.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "glyph_contour_tracer_unit_assert.svh"

module glyph_contour_tracer_unit
  import gct_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_char_code,
  input  logic signed [COORD_BITS-1:0]  in_origin_x,
  input  logic signed [COORD_BITS-1:0]  in_origin_y,
  input  logic [11:0]                   in_cell_width,
  input  logic [11:0]                   in_cell_height,
  output logic                          out_strobe,
  output logic                          out_kind,
  output logic signed [COORD_BITS-1:0]  out_point_x,
  output logic signed [COORD_BITS-1:0]  out_point_y,
  output logic                          out_last
);

  function automatic logic pix(logic [19:0] g, logic signed [3:0] x, logic signed [3:0] y);
    logic [3:0] row;
    logic       b;
    row = '0;
    b   = 1'b0;
    unique case (y)
      4'sd0:   row = g[19:16];
      4'sd1:   row = g[15:12];
      4'sd2:   row = g[11:8];
      4'sd3:   row = g[7:4];
      4'sd4:   row = g[3:0];
      default: row = '0;
    endcase
    if (x >= 4'sd0 && x <= 4'sd3) begin
      b = row[2'd3 - x[1:0]];
    end
    return b;
  endfunction

  function automatic logic [4:0] corner_idx(logic [2:0] x, logic [2:0] y);
    return 5'({2'b0, y} * 5'(GLYPH_W + 1) + {2'b0, x});
  endfunction

  st_t                    state_r, state_nxt;
  logic [19:0]            glyph_r, glyph_nxt;
  scale_cfg_t             cfg_r, cfg_nxt;
  logic [11:0]            h_r, h_nxt;
  logic [2:0]             si_r, si_nxt;
  logic [2:0]             sj_r, sj_nxt;
  logic [2:0]             cx_r, cx_nxt;
  logic [2:0]             cy_r, cy_nxt;
  dir_t                   dir_r, dir_nxt;
  logic [6:0]             steps_r, steps_nxt;
  logic [29:0]            seen_r, seen_nxt;
  logic [5:0]             nout_r, nout_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic                   pend_kind_r, pend_kind_nxt;
  logic [COORD_BITS-1:0]  pend_x_r, pend_x_nxt;
  logic [COORD_BITS-1:0]  pend_y_r, pend_y_nxt;
  logic                   strobe_r, strobe_nxt;
  logic                   okind_r, okind_nxt;
  logic [COORD_BITS-1:0]  ox_r, ox_nxt;
  logic [COORD_BITS-1:0]  oy_r, oy_nxt;
  logic                   olast_r, olast_nxt;

  logic [2:0]             pt_gx, pt_gy;
  logic [COORD_BITS-1:0]  pt_x, pt_y;
  logic [23:0]            hq_prod;
  logic [11:0]            hq_times;
  logic signed [3:0]      sx, sy, nx, ny;
  dir_t                   nd;
  logic                   walk_done;
  logic signed [3:0]      scx, scy;
  logic                   scan_start;
  logic                   scan_last;
  logic                   emit_v, emit_kind;
  logic [COORD_BITS-1:0]  emit_x, emit_y;

  gct_scale u_scale (
    .cfg (cfg_r),
    .gx  (pt_gx),
    .gy  (pt_gy),
    .px  (pt_x),
    .py  (pt_y)
  );

  always_comb begin
    hq_prod  = 24'(h_r) * 24'(RECIP_H);
    hq_times = 12'({cfg_r.hq, 2'b00}) + 12'(cfg_r.hq);

    scx = signed'({1'b0, si_r});
    scy = signed'({1'b0, sj_r});
    scan_start = !pix(glyph_r, scx, scy - 4'sd1) && pix(glyph_r, scx, scy) &&
                 !seen_r[corner_idx(si_r, sj_r)];
    scan_last  = (si_r == 3'(GLYPH_W)) && (sj_r == 3'(GLYPH_H));

    sx = signed'({1'b0, cx_r});
    sy = signed'({1'b0, cy_r});
    nx = sx;
    ny = sy;
    unique case (dir_r)
      DIR_RIGHT: begin
        nx = sx + 4'sd1;
        nd = pix(glyph_r, nx, sy - 4'sd1) ? DIR_UP :
             (pix(glyph_r, nx, sy) ? DIR_RIGHT : DIR_DOWN);
      end
      DIR_DOWN: begin
        ny = sy + 4'sd1;
        nd = pix(glyph_r, sx, ny) ? DIR_RIGHT :
             (pix(glyph_r, sx - 4'sd1, ny) ? DIR_DOWN : DIR_LEFT);
      end
      DIR_LEFT: begin
        nx = sx - 4'sd1;
        nd = pix(glyph_r, nx - 4'sd1, sy) ? DIR_DOWN :
             (pix(glyph_r, nx - 4'sd1, sy - 4'sd1) ? DIR_LEFT : DIR_UP);
      end
      default: begin
        ny = sy - 4'sd1;
        nd = pix(glyph_r, sx - 4'sd1, ny - 4'sd1) ? DIR_LEFT :
             (pix(glyph_r, sx, ny - 4'sd1) ? DIR_UP : DIR_RIGHT);
      end
    endcase
    walk_done = (nx[2:0] == si_r && ny[2:0] == sj_r && nd == DIR_RIGHT) ||
                (steps_r + 7'd1 == 7'(WALK_LIMIT));

    pt_gx = (state_r == ST_WALK) ? cx_r : si_r;
    pt_gy = (state_r == ST_WALK) ? cy_r : sj_r;
  end

  always_comb begin
    state_nxt     = state_r;
    glyph_nxt     = glyph_r;
    cfg_nxt       = cfg_r;
    h_nxt         = h_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    dir_nxt       = dir_r;
    steps_nxt     = steps_r;
    seen_nxt      = seen_r;
    nout_nxt      = nout_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    strobe_nxt    = 1'b0;
    okind_nxt     = okind_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    olast_nxt     = olast_r;
    emit_v        = 1'b0;
    emit_kind     = KIND_POINT;
    emit_x        = pt_x;
    emit_y        = pt_y;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          glyph_nxt  = glyph_lookup(in_char_code);
          cfg_nxt.ox = in_origin_x;
          cfg_nxt.oy = in_origin_y;
          cfg_nxt.wq = in_cell_width[11:2];
          cfg_nxt.wr = in_cell_width[1:0];
          h_nxt      = in_cell_height;
          si_nxt     = '0;
          sj_nxt     = '0;
          seen_nxt   = '0;
          nout_nxt   = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_PREP_Q;
        end
      end
      ST_PREP_Q: begin
        cfg_nxt.hq = hq_prod[RECIP_SH +: 10];
        state_nxt  = ST_PREP_R;
      end
      ST_PREP_R: begin
        cfg_nxt.hr = 3'(h_r - hq_times);
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_start) begin
          emit_v    = 1'b1;
          emit_kind = KIND_JUMP;
          emit_x    = '0;
          emit_y    = '0;
          cx_nxt    = si_r;
          cy_nxt    = sj_r;
          dir_nxt   = DIR_RIGHT;
          steps_nxt = '0;
          state_nxt = ST_WALK;
        end else if (scan_last) begin
          state_nxt = ST_FLUSH;
        end else if (si_r == 3'(GLYPH_W)) begin
          si_nxt = '0;
          sj_nxt = sj_r + 3'd1;
        end else begin
          si_nxt = si_r + 3'd1;
        end
      end
      ST_WALK: begin
        emit_v = 1'b1;
        if (dir_r == DIR_RIGHT) begin
          seen_nxt[corner_idx(cx_r, cy_r)] = 1'b1;
        end
        cx_nxt    = nx[2:0];
        cy_nxt    = ny[2:0];
        dir_nxt   = nd;
        steps_nxt = steps_r + 7'd1;
        if (walk_done) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        emit_v = 1'b1;
        if (scan_last) begin
          state_nxt = ST_FLUSH;
        end else if (si_r == 3'(GLYPH_W)) begin
          si_nxt    = '0;
          sj_nxt    = sj_r + 3'd1;
          state_nxt = ST_SCAN;
        end else begin
          si_nxt    = si_r + 3'd1;
          state_nxt = ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          strobe_nxt = 1'b1;
          okind_nxt  = pend_kind_r;
          ox_nxt     = pend_x_r;
          oy_nxt     = pend_y_r;
          olast_nxt  = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit_v && nout_r < 6'(MAX_OUT)) begin
      nout_nxt = nout_r + 6'd1;
      if (pend_v_r) begin
        strobe_nxt = 1'b1;
        okind_nxt  = pend_kind_r;
        ox_nxt     = pend_x_r;
        oy_nxt     = pend_y_r;
        olast_nxt  = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = emit_kind;
      pend_x_nxt    = emit_x;
      pend_y_nxt    = emit_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
      nout_r   <= '0;
      steps_r  <= '0;
      seen_r   <= '0;
      si_r     <= '0;
      sj_r     <= '0;
      dir_r    <= DIR_RIGHT;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      strobe_r <= strobe_nxt;
      nout_r   <= nout_nxt;
      steps_r  <= steps_nxt;
      seen_r   <= seen_nxt;
      si_r     <= si_nxt;
      sj_r     <= sj_nxt;
      dir_r    <= dir_nxt;
    end
    glyph_r     <= glyph_nxt;
    cfg_r       <= cfg_nxt;
    h_r         <= h_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    okind_r     <= okind_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    olast_r     <= olast_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_strobe  = strobe_r;
  assign out_kind    = okind_r;
  assign out_point_x = ox_r;
  assign out_point_y = oy_r;
  assign out_last    = olast_r;

  `GCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted item did not raise busy.")
  `GCT_ASSERT_NEXT(a_last_ends, out_strobe && out_last, !out_strobe, "Result followed last.")
  `GCT_ASSERT(a_nout_cap, nout_r <= 6'(MAX_OUT), "Result count passed its limit.")
  `GCT_ASSERT_IMP(a_walk_pend, state_r == ST_WALK, pend_v_r, "Walk without a pending result.")
  `GCT_ASSERT_IMP(a_strobe_src, out_strobe, $past(state_r == ST_SCAN || state_r == ST_WALK || state_r == ST_CLOSE || state_r == ST_FLUSH), "Result strobe from a state that emits none.")

endmodule

// ----- src/gct_scale.sv -----
module gct_scale
  import gct_pkg::*;
(
  input  scale_cfg_t             cfg,
  input  logic [2:0]             gx,
  input  logic [2:0]             gy,
  output logic [COORD_BITS-1:0]  px,
  output logic [COORD_BITS-1:0]  py
);

  logic [12:0] x_main;
  logic [12:0] y_main;
  logic [4:0]  x_frac;
  logic [4:0]  y_frac;
  logic [2:0]  x_round;
  logic [2:0]  y_round;

  always_comb begin
    x_main  = 13'(gx) * 13'(cfg.wq);
    y_main  = 13'(gy) * 13'(cfg.hq);
    x_frac  = 5'(gx) * 5'(cfg.wr) + 5'(GLYPH_W / 2);
    y_frac  = 5'(gy) * 5'(cfg.hr) + 5'(GLYPH_H / 2);
    x_round = 3'(x_frac >> 2);
    y_round = div_h_small(y_frac);
    px = cfg.ox + COORD_BITS'(x_main) + COORD_BITS'(x_round);
    py = cfg.oy + COORD_BITS'(y_main) + COORD_BITS'(y_round);
  end

endmodule

// ----- tb/glyph_contour_tracer_unit_test.sv -----
`timescale 1ns / 100ps

module glyph_contour_tracer_unit_test
  import gct_pkg::*;
();

  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 120;
  localparam int MAX_GAP     = 96;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } trace_pt_t;

  class trace_scoreboard;
    logic [19:0] font [96];
    trace_pt_t   outline_q [$];
    int          n_errors;
    int          n_chars;
    int          n_blank;
    int          n_jumps;
    int          n_points;

    function new();
      font = '{
        20'h00000, 20'h44404, 20'hAA000, 20'h6F6F6, 20'h7A65E, 20'h7E47E, 20'h694A7, 20'h22000,
        20'h48884, 20'h42224, 20'h96F69, 20'h02720, 20'h00024, 20'h00700, 20'h00004, 20'h11248,
        20'h6BFD6, 20'h26222, 20'hE168F, 20'hE161E, 20'h26AF2, 20'hF8E1E, 20'h68E96, 20'hF1248,
        20'h69696, 20'h69F16, 20'h04040, 20'h04048, 20'h24842, 20'h0F0F0, 20'h42124, 20'h69202,
        20'h69356, 20'hF9F99, 20'hE9E9E, 20'hF888F, 20'hE999E, 20'hF8E8F, 20'hF8E88, 20'hF8B9F,
        20'h99F99, 20'hE444E, 20'hF1196, 20'h9ACA9, 20'h8888F, 20'hEFFDD, 20'h9DB99, 20'hF999F,
        20'hE9E88, 20'hF99BF, 20'hE9E99, 20'h7861E, 20'hF2222, 20'h9999F, 20'h999A4, 20'h9BBFE,
        20'h99699, 20'h99716, 20'hF248F, 20'hE888E, 20'h88421, 20'h71117, 20'h4A000, 20'h0000F,
        20'h42000, 20'h05BB5, 20'h88E9E, 20'h07887, 20'h11797, 20'h69F87, 20'h34E44, 20'h79717,
        20'h88E99, 20'h02022, 20'h10116, 20'h8ACA9, 20'hC444E, 20'h0EDDD, 20'h0E999, 20'h06996,
        20'h0E9E8, 20'h06971, 20'h0BC88, 20'h0742E, 20'h4E443, 20'h09996, 20'h09966, 20'h09FF6,
        20'h09669, 20'h09716, 20'h0F24F, 20'h64C46, 20'h44444, 20'hC464C, 20'h005A0, 20'hF999F
      };
      n_errors = 0;
      n_chars  = 0;
      n_blank  = 0;
      n_jumps  = 0;
      n_points = 0;
    endfunction

    function bit lit(logic [19:0] g, int px, int py);
      if (px < 0 || px >= GLYPH_W || py < 0 || py >= GLYPH_H) return 1'b0;
      return g[GLYPH_W * GLYPH_H - 1 - GLYPH_W * py - px];
    endfunction

    function logic [COORD_BITS-1:0] corner(int org, int g, int span, int n);
      return COORD_BITS'(org + g * (span / n) + (g * (span % n) + n / 2) / n);
    endfunction

    function void add_pt(int base, logic kind, logic [COORD_BITS-1:0] x,
                         logic [COORD_BITS-1:0] y);
      trace_pt_t pt;
      if (outline_q.size() - base >= MAX_OUT) return;
      pt.kind = kind;
      pt.x    = x;
      pt.y    = y;
      pt.last = 1'b0;
      outline_q.push_back(pt);
      if (kind == KIND_JUMP) n_jumps++;
      else n_points++;
    endfunction

    function void note_char(logic [7:0] code, logic signed [COORD_BITS-1:0] ox,
                            logic signed [COORD_BITS-1:0] oy, logic [11:0] w, logic [11:0] h);
      logic [19:0] g;
      logic [29:0] seen;
      int          base;
      int          cx;
      int          cy;
      int          nx;
      int          ny;
      int          steps;
      dir_t        d;
      dir_t        nd;
      n_chars++;
      base = outline_q.size();
      seen = '0;
      if (code == 8'(CHAR_FIRST)) begin
        n_blank++;
        return;
      end
      g = (code >= CHAR_FIRST && code < CHAR_END) ? font[code - CHAR_FIRST] : font[BOX_INDEX];
      for (int j = 0; j <= GLYPH_H; j++) begin
        for (int i = 0; i <= GLYPH_W; i++) begin
          if (lit(g, i, j - 1) || !lit(g, i, j) || seen[j * (GLYPH_W + 1) + i]) continue;
          add_pt(base, KIND_JUMP, '0, '0);
          cx    = i;
          cy    = j;
          d     = DIR_RIGHT;
          steps = 0;
          do begin
            nx = cx;
            ny = cy;
            if (d == DIR_RIGHT && cx >= 0 && cx <= GLYPH_W && cy >= 0 && cy <= GLYPH_H) begin
              seen[cy * (GLYPH_W + 1) + cx] = 1'b1;
            end
            add_pt(base, KIND_POINT, corner(ox, cx, w, GLYPH_W), corner(oy, cy, h, GLYPH_H));
            if (d == DIR_RIGHT) begin
              nx = cx + 1;
              nd = lit(g, nx, ny - 1) ? DIR_UP : (lit(g, nx, ny) ? DIR_RIGHT : DIR_DOWN);
            end else if (d == DIR_DOWN) begin
              ny = cy + 1;
              nd = lit(g, nx, ny) ? DIR_RIGHT : (lit(g, nx - 1, ny) ? DIR_DOWN : DIR_LEFT);
            end else if (d == DIR_LEFT) begin
              nx = cx - 1;
              nd = lit(g, nx - 1, ny) ? DIR_DOWN : (lit(g, nx - 1, ny - 1) ? DIR_LEFT : DIR_UP);
            end else begin
              ny = cy - 1;
              nd = lit(g, nx - 1, ny - 1) ? DIR_LEFT : (lit(g, nx, ny - 1) ? DIR_UP : DIR_RIGHT);
            end
            cx = nx;
            cy = ny;
            d  = nd;
            steps++;
          end while ((cx != i || cy != j || d != DIR_RIGHT) && steps < WALK_LIMIT);
          add_pt(base, KIND_POINT, corner(ox, i, w, GLYPH_W), corner(oy, j, h, GLYPH_H));
        end
      end
      if (outline_q.size() > base) outline_q[outline_q.size() - 1].last = 1'b1;
    endfunction

    task report(string what, int got, int want);
      if (n_errors < 40) begin
        $display("[%0t] mismatch in %s: got %0h, wanted %0h", $time, what, got, want);
      end
      n_errors++;
    endtask

    task check_point(logic kind, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                     logic last);
      trace_pt_t want;
      if (outline_q.size() == 0) begin
        report("unexpected beat, kind", kind, 0);
        return;
      end
      want = outline_q.pop_front();
      if (kind !== want.kind) report("kind", kind, want.kind);
      if (x !== want.x) report("point_x", x, want.x);
      if (y !== want.y) report("point_y", y, want.y);
      if (last !== want.last) report("last", last, want.last);
    endtask

    task check_leftover();
      if (outline_q.size() != 0) report("results never delivered, count", outline_q.size(), 0);
    endtask
  endclass

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic [7:0]                   in_char_code   = '0;
  logic signed [COORD_BITS-1:0] in_origin_x    = '0;
  logic signed [COORD_BITS-1:0] in_origin_y    = '0;
  logic [11:0]                  in_cell_width  = '0;
  logic [11:0]                  in_cell_height = '0;
  logic                         out_strobe;
  logic                         out_kind;
  logic signed [COORD_BITS-1:0] out_point_x;
  logic signed [COORD_BITS-1:0] out_point_y;
  logic                         out_last;
  int                           quiet_cycles   = 0;
  trace_scoreboard              sb;

  glyph_contour_tracer_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_char_code   (in_char_code),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_cell_width  (in_cell_width),
    .in_cell_height (in_cell_height),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_char(in_char_code, in_origin_x, in_origin_y, in_cell_width, in_cell_height);
      end
      if (out_strobe) sb.check_point(out_kind, out_point_x, out_point_y, out_last);
      if ((start && !busy) || out_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_char(logic [7:0] code, logic [15:0] ox, logic [15:0] oy,
                           logic [11:0] w, logic [11:0] h, int idle_pct);
    int gap;
    start          <= 1'b1;
    in_char_code   <= code;
    in_origin_x    <= ox;
    in_origin_y    <= oy;
    in_cell_width  <= w;
    in_cell_height <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int idle_pct);
    int          sel;
    logic [7:0]  code;
    logic [11:0] w;
    logic [11:0] h;
    sel = $urandom_range(99);
    if (sel < 75) code = 8'($urandom_range(CHAR_FIRST + 1, CHAR_END - 1));
    else if (sel < 82) code = 8'(CHAR_FIRST);
    else code = 8'($urandom);
    w = 12'($urandom);
    h = 12'($urandom);
    if ($urandom_range(3) == 0) begin
      w = 12'($urandom_range(0, 40));
      h = 12'($urandom_range(0, 40));
    end
    send_char(code, 16'($urandom), 16'($urandom), w, h, idle_pct);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outline_q.size() != 0 || busy) @(posedge clk);
  endtask

  initial begin
    int idle_mix [4];
    idle_mix = '{0, 49, 0, 20};
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(8'd32, 16'h0000, 16'h0000, 12'd0, 12'd0, 0);
    send_char(8'h00, 16'h0000, 16'h0000, 12'd4095, 12'd4095, 0);
    send_char(8'hFF, 16'h8000, 16'h8000, 12'd0, 12'd0, 0);
    send_char(8'd31, 16'h7FFF, 16'h7FFF, 12'd4095, 12'd4095, 0);
    send_char(8'd127, 16'hFFFF, 16'h0001, 12'd17, 12'd23, 0);
    send_char(8'd126, 16'h1234, 16'hFEDC, 12'd40, 12'd50, 0);
    send_char(8'd33, 16'h0010, 16'h0020, 12'd4, 12'd5, 0);
    send_char("B", 16'h0000, 16'h0000, 12'd4, 12'd5, 0);
    send_char("8", 16'h0100, 16'h0200, 12'd7, 12'd9, 0);
    send_char("0", 16'hFFF0, 16'h0000, 12'd5, 12'd6, 0);
    send_char("%", 16'h0000, 16'hFFF0, 12'd6, 12'd7, 0);
    send_char("M", 16'h4000, 16'hC000, 12'd1023, 12'd1024, 0);
    send_char("@", 16'h0000, 16'h0000, 12'd100, 12'd100, 0);
    send_char("A", 16'hFFFB, 16'h7FF8, 12'd300, 12'd300, 0);
    send_char("#", 16'h8000, 16'h7FFF, 12'd4095, 12'd1, 0);
    send_char("g", 16'h0333, 16'h0444, 12'd2, 12'd3, 0);
    send_char(".", 16'h0000, 16'h0000, 12'd8, 12'd10, 0);
    send_char("O", 16'h5555, 16'hAAAA, 12'd4094, 12'd4093, 0);
    send_char("m", 16'h0000, 16'h0000, 12'd4093, 12'd4092, 0);
    send_char("W", 16'h0FFF, 16'hF000, 12'd4091, 12'd4091, 0);
    send_char("&", 16'h0001, 16'hFFFF, 12'd12, 12'd15, 0);
    send_char(8'd32, 16'h7FFF, 16'h8000, 12'd4095, 12'd4095, 0);
    send_char("q", 16'h0000, 16'h0000, 12'd3, 12'd4, 0);
    drain();

    foreach (idle_mix[p]) begin
      for (int n = 0; n < 50; n++) begin
        send_random(idle_mix[p]);
        if (n == 27 && idle_mix[p] != 0) drain();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_leftover();
    $display("Traced %0d characters (%0d blank), compared %0d contour jumps and %0d points.",
             sb.n_chars, sb.n_blank, sb.n_jumps, sb.n_points);
    $display("Sender ran back to back and with 49 and 20 percent idle gaps, draining between.");
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/gct_pkg.sv
src/gct_scale.sv
src/glyph_contour_tracer_unit.sv
tb/glyph_contour_tracer_unit_test.sv
